[rtl/ebn_pkg.sv]
`timescale 1ns / 1ps

package ebn_pkg;

    localparam int TAP_COUNT_DEF     = 129;
    localparam int WINDOW_LENGTH_DEF = 250;
    localparam int COEFF_WIDTH_DEF   = 16;

    localparam int SAMPLE_W  = 24;
    localparam int FILT_W    = 26;
    localparam int LEVEL_W   = 8;
    localparam int TABLE_LEN = 129;

    localparam int OUT_MAX     = 33554431;
    localparam int OUT_MIN     = -33554432;
    localparam int LEVEL_LOW   = 5;
    localparam int LEVEL_HIGH  = 180;
    localparam int LEVEL_SCALE = 175;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MAC,
        S_MAC_DRAIN,
        S_ROUND,
        S_WRITE,
        S_SCAN,
        S_SCAN_DRAIN,
        S_SCALE,
        S_DIV,
        S_DONE
    } ebn_state_t;

    // Bandpass taps, Q1.15, symmetric around the center tap.
    localparam logic signed [15:0] BP_Q15 [TABLE_LEN] = '{
        16'sd1, 16'sd8, 16'sd19, 16'sd28, 16'sd30, 16'sd24, 16'sd12, 16'sd1, -16'sd2, 16'sd6,
        16'sd24, 16'sd44, 16'sd54, 16'sd46, 16'sd23, -16'sd7, -16'sd25, -16'sd19, 16'sd11,
        16'sd51, 16'sd78, 16'sd69, 16'sd22, -16'sd46, -16'sd102, -16'sd113, -16'sd71, 16'sd3,
        16'sd64, 16'sd66, -16'sd10, -16'sd140, -16'sd265, -16'sd321, -16'sd276, -16'sd151,
        -16'sd20, 16'sd26, -16'sd65, -16'sd275, -16'sd514, -16'sd661, -16'sd632, -16'sd433,
        -16'sd170, -16'sd4, -16'sd64, -16'sd369, -16'sd797, -16'sd1134, -16'sd1181, -16'sd873,
        -16'sd334, 16'sd148, 16'sd262, -16'sd161, -16'sd1024, -16'sd1950, -16'sd2413,
        -16'sd1962, -16'sd443, 16'sd1885, 16'sd4401, 16'sd6335, 16'sd7061,
        16'sd6335, 16'sd4401, 16'sd1885, -16'sd443, -16'sd1962, -16'sd2413, -16'sd1950,
        -16'sd1024, -16'sd161, 16'sd262, 16'sd148, -16'sd334, -16'sd873, -16'sd1181,
        -16'sd1134, -16'sd797, -16'sd369, -16'sd64, -16'sd4, -16'sd170, -16'sd433, -16'sd632,
        -16'sd661, -16'sd514, -16'sd275, -16'sd65, 16'sd26, -16'sd20, -16'sd151, -16'sd276,
        -16'sd321, -16'sd265, -16'sd140, -16'sd10, 16'sd66, 16'sd64, 16'sd3, -16'sd71,
        -16'sd113, -16'sd102, -16'sd46, 16'sd22, 16'sd69, 16'sd78, 16'sd51, 16'sd11, -16'sd19,
        -16'sd25, -16'sd7, 16'sd23, 16'sd46, 16'sd54, 16'sd44, 16'sd24, 16'sd6, -16'sd2,
        16'sd1, 16'sd12, 16'sd24, 16'sd30, 16'sd28, 16'sd19, 16'sd8, 16'sd1
    };

    // Coefficient for tap k at a coefficient width of cw bits. Narrower
    // widths round half away from zero; taps past the table are zero.
    function automatic logic signed [32:0] coeff_at(input int unsigned k, input int cw);
        logic signed [32:0] c;
        logic signed [32:0] h;
        int                 s;
        c = 33'sd0;
        h = 33'sd0;
        s = 0;
        if (k >= TABLE_LEN) begin
            return 33'sd0;
        end
        c = 33'(BP_Q15[k]);
        if (cw >= 16) begin
            return c <<< (cw - 16);
        end
        s = 16 - cw;
        h = 33'sd1 <<< (s - 1);
        if (c >= 0) begin
            return (c + h) >>> s;
        end
        return -((-c + h) >>> s);
    endfunction

endpackage

[rtl/ebn_ram.sv]
`timescale 1ns / 1ps

module ebn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ecg_bandpass_minmax_normalizer_top.sv]
`timescale 1ns / 1ps

// ECG bandpass filter with sliding-window min/max display normalizer.
//
// Input channel: in_valid/in_ready carry one signed 24-bit ECG sample per
// transfer. Output channel: out_valid/out_ready carry the filtered value
// (26-bit signed, FIR output truncated toward zero and saturated) and the
// display level (5..180), one result per input transfer, in order.
//
// Each sample walks every tap through the shared multiplier that reads the
// delay-line RAM, scans every entry of the window RAM for the min/max, and
// runs the 35-bit restoring divider, plus pipeline drain steps.
// A new sample is taken while the previous result still waits in the
// output register; if the receiver stalls, the block finishes the next
// sample and then holds in its last step until the output slot frees.
//
// After reset the block sweeps both RAMs to zero, one entry per cycle across
// max(TAP_COUNT-1, WINDOW_LENGTH) addresses (250 by default), with in_ready low.
module ecg_bandpass_minmax_normalizer_top #(
    parameter int TAP_COUNT     = ebn_pkg::TAP_COUNT_DEF,
    parameter int WINDOW_LENGTH = ebn_pkg::WINDOW_LENGTH_DEF,
    parameter int COEFF_WIDTH   = ebn_pkg::COEFF_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [ebn_pkg::SAMPLE_W-1:0] ecg_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ebn_pkg::FILT_W-1:0]   filtered_value,
    output logic        [ebn_pkg::LEVEL_W-1:0]  display_level
);

    localparam int SW      = ebn_pkg::SAMPLE_W;
    localparam int FW      = ebn_pkg::FILT_W;
    localparam int DL_D    = TAP_COUNT - 1;
    localparam int DL_AW   = (DL_D > 1) ? $clog2(DL_D) : 1;
    localparam int RG_AW   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int TAP_W   = $clog2(TAP_COUNT);
    localparam int PROD_W  = COEFF_WIDTH + SW;
    localparam int ACC_W   = PROD_W + $clog2(TAP_COUNT);
    localparam int CLR_N   = (DL_D > WINDOW_LENGTH) ? DL_D : WINDOW_LENGTH;
    localparam int CLR_W   = $clog2(CLR_N + 1);
    localparam int DIFF_W  = FW + 1;
    localparam int NUM_W   = DIFF_W + 8;
    localparam int DIV_CW  = $clog2(NUM_W + 1);

    localparam logic signed [ACC_W-1:0] Y_HI = ACC_W'(ebn_pkg::OUT_MAX);
    localparam logic signed [ACC_W-1:0] Y_LO = ACC_W'(ebn_pkg::OUT_MIN);
    localparam logic signed [ACC_W-1:0] RND  = ACC_W'((64'sd1 <<< (COEFF_WIDTH - 1)) - 1);

    ebn_pkg::ebn_state_t state_reg, state_next;

    logic [CLR_W-1:0]   clr_reg;
    logic [TAP_W-1:0]   tap_reg;
    logic [DL_AW-1:0]   dl_ptr_reg;
    logic [DL_AW-1:0]   dl_raddr_reg;
    logic [RG_AW-1:0]   rg_ptr_reg;
    logic [RG_AW-1:0]   scan_reg;
    logic [DIV_CW-1:0]  div_cnt_reg;
    logic               p1_vld_reg, p2_vld_reg, s1_vld_reg;
    logic [TAP_W-1:0]   p1_tap_reg;
    logic signed [SW-1:0]     x_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [FW-1:0]     y_reg, lo_reg, hi_reg;
    logic [DIFF_W-1:0]        den_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DIFF_W:0]          rem_reg;
    logic                     out_valid_reg;
    logic signed [FW-1:0]     filt_out_reg;
    logic [ebn_pkg::LEVEL_W-1:0] level_out_reg;

    logic              dl_we;
    logic [DL_AW-1:0]  dl_waddr;
    logic [SW-1:0]     dl_wdata, dl_rdata;
    logic              rg_we;
    logic [RG_AW-1:0]  rg_waddr;
    logic [FW-1:0]     rg_wdata, rg_rdata;

    logic                     in_fire, out_free;
    logic signed [SW-1:0]     mac_sample;
    logic signed [COEFF_WIDTH-1:0] mac_coeff;
    logic signed [ACC_W-1:0]  acc_adj, acc_q;
    logic signed [FW-1:0]     y_sat;
    logic signed [FW-1:0]     rg_s;
    logic [DIFF_W-1:0]        diff, span;
    logic [DIFF_W:0]          rem_sh;
    logic                     rem_ge;
    logic [ebn_pkg::LEVEL_W-1:0] level;

    assign in_ready  = (state_reg == ebn_pkg::S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign filtered_value = filt_out_reg;
    assign display_level  = level_out_reg;

    ebn_ram #(.WIDTH(SW), .DEPTH(DL_D), .AW(DL_AW)) u_dl_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (dl_raddr_reg),
        .rdata (dl_rdata)
    );

    ebn_ram #(.WIDTH(FW), .DEPTH(WINDOW_LENGTH), .AW(RG_AW)) u_rg_ram (
        .clk   (clk),
        .we    (rg_we),
        .waddr (rg_waddr),
        .wdata (rg_wdata),
        .raddr (scan_reg),
        .rdata (rg_rdata)
    );

    // RAM write ports: the clearing sweep, then one write per sample each.
    always_comb
    begin
        dl_we    = 1'b0;
        dl_waddr = dl_ptr_reg;
        dl_wdata = x_reg;
        rg_we    = 1'b0;
        rg_waddr = rg_ptr_reg;
        rg_wdata = y_reg;
        if (state_reg == ebn_pkg::S_CLEAR) begin
            dl_we    = (clr_reg < CLR_W'(DL_D));
            dl_waddr = clr_reg[DL_AW-1:0];
            dl_wdata = '0;
            rg_we    = (clr_reg < CLR_W'(WINDOW_LENGTH));
            rg_waddr = clr_reg[RG_AW-1:0];
            rg_wdata = '0;
        end else if (state_reg == ebn_pkg::S_ROUND) begin
            dl_we = 1'b1;
        end else if (state_reg == ebn_pkg::S_WRITE) begin
            rg_we = 1'b1;
        end
    end

    // Datapath helpers.
    always_comb
    begin
        mac_sample = (p1_tap_reg == '0) ? x_reg : $signed(dl_rdata);
        mac_coeff  = COEFF_WIDTH'(ebn_pkg::coeff_at(32'(p1_tap_reg), COEFF_WIDTH));
        acc_adj    = (acc_reg < 0) ? (acc_reg + RND) : acc_reg;
        acc_q      = acc_adj >>> (COEFF_WIDTH - 1);
        if (acc_q > Y_HI) begin
            y_sat = FW'(Y_HI);
        end else if (acc_q < Y_LO) begin
            y_sat = FW'(Y_LO);
        end else begin
            y_sat = acc_q[FW-1:0];
        end
        rg_s   = $signed(rg_rdata);
        diff   = DIFF_W'($signed({y_reg[FW-1], y_reg}) - $signed({lo_reg[FW-1], lo_reg}));
        span   = DIFF_W'($signed({hi_reg[FW-1], hi_reg}) - $signed({lo_reg[FW-1], lo_reg}));
        rem_sh = {rem_reg[DIFF_W-1:0], num_reg[NUM_W-1]};
        rem_ge = (rem_sh >= {1'b0, den_reg});
        if (num_reg > NUM_W'(ebn_pkg::LEVEL_SCALE)) begin
            level = ebn_pkg::LEVEL_W'(ebn_pkg::LEVEL_HIGH);
        end else begin
            level = num_reg[ebn_pkg::LEVEL_W-1:0] + ebn_pkg::LEVEL_W'(ebn_pkg::LEVEL_LOW);
        end
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ebn_pkg::S_CLEAR:
                if (clr_reg == CLR_W'(CLR_N - 1)) state_next = ebn_pkg::S_IDLE;
            ebn_pkg::S_IDLE:
                if (in_fire) state_next = ebn_pkg::S_MAC;
            ebn_pkg::S_MAC:
                if (tap_reg == TAP_W'(TAP_COUNT - 1)) state_next = ebn_pkg::S_MAC_DRAIN;
            ebn_pkg::S_MAC_DRAIN:
                if (!p1_vld_reg && !p2_vld_reg) state_next = ebn_pkg::S_ROUND;
            ebn_pkg::S_ROUND:
                state_next = ebn_pkg::S_WRITE;
            ebn_pkg::S_WRITE:
                state_next = ebn_pkg::S_SCAN;
            ebn_pkg::S_SCAN:
                if (scan_reg == RG_AW'(WINDOW_LENGTH - 1)) state_next = ebn_pkg::S_SCAN_DRAIN;
            ebn_pkg::S_SCAN_DRAIN:
                if (!s1_vld_reg) state_next = ebn_pkg::S_SCALE;
            ebn_pkg::S_SCALE:
                state_next = ebn_pkg::S_DIV;
            ebn_pkg::S_DIV:
                if (div_cnt_reg == DIV_CW'(NUM_W - 1)) state_next = ebn_pkg::S_DONE;
            ebn_pkg::S_DONE:
                if (out_free) state_next = ebn_pkg::S_IDLE;
            default:
                state_next = ebn_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ebn_pkg::S_CLEAR;
            clr_reg       <= '0;
            dl_ptr_reg    <= '0;
            rg_ptr_reg    <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            s1_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            p1_vld_reg <= (state_reg == ebn_pkg::S_MAC);
            p2_vld_reg <= p1_vld_reg;
            s1_vld_reg <= (state_reg == ebn_pkg::S_SCAN);
            if (state_reg == ebn_pkg::S_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ebn_pkg::S_ROUND) begin
                dl_ptr_reg <= (dl_ptr_reg == DL_AW'(DL_D - 1)) ? '0 : dl_ptr_reg + 1'b1;
            end
            if (state_reg == ebn_pkg::S_WRITE) begin
                rg_ptr_reg <= (rg_ptr_reg == RG_AW'(WINDOW_LENGTH - 1)) ?
                              '0 : rg_ptr_reg + 1'b1;
            end
            if (state_reg == ebn_pkg::S_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            x_reg        <= ecg_sample;
            acc_reg      <= '0;
            tap_reg      <= '0;
            dl_raddr_reg <= (dl_ptr_reg == '0) ? DL_AW'(DL_D - 1) : dl_ptr_reg - 1'b1;
        end
        if (state_reg == ebn_pkg::S_MAC) begin
            tap_reg <= tap_reg + 1'b1;
            if (tap_reg != '0) begin
                dl_raddr_reg <= (dl_raddr_reg == '0) ? DL_AW'(DL_D - 1) : dl_raddr_reg - 1'b1;
            end
        end
        p1_tap_reg <= tap_reg;
        prod_reg   <= PROD_W'(mac_coeff * mac_sample);
        if (p2_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (state_reg == ebn_pkg::S_ROUND) begin
            y_reg <= y_sat;
        end
        if (state_reg == ebn_pkg::S_WRITE) begin
            lo_reg   <= y_reg;
            hi_reg   <= y_reg;
            scan_reg <= '0;
        end
        if (state_reg == ebn_pkg::S_SCAN) begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (s1_vld_reg) begin
            if (rg_s < lo_reg) lo_reg <= rg_s;
            if (rg_s > hi_reg) hi_reg <= rg_s;
        end
        if (state_reg == ebn_pkg::S_SCALE) begin
            den_reg     <= (span == '0) ? DIFF_W'(1) : span;
            num_reg     <= NUM_W'(diff * 8'(ebn_pkg::LEVEL_SCALE));
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        // Restoring division, one quotient bit per cycle shifted into num_reg.
        if (state_reg == ebn_pkg::S_DIV) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            rem_reg     <= rem_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            num_reg     <= {num_reg[NUM_W-2:0], rem_ge};
        end
        if (state_reg == ebn_pkg::S_DONE && out_free) begin
            filt_out_reg  <= y_reg;
            level_out_reg <= level;
        end
    end

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (display_level >= 8'd5 && display_level <= 8'd180))
        else $error("display level out of range");

    a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ebn_pkg::S_MAC))
        else $error("accepted sample did not start the tap walk");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ebn_pkg::S_CLEAR) |-> !in_ready)
        else $error("input taken during clearing sweep");

    a_mac_pipe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        p2_vld_reg |-> (state_reg == ebn_pkg::S_MAC || state_reg == ebn_pkg::S_MAC_DRAIN))
        else $error("product accumulated outside the tap walk");

endmodule
